// File: rtl/nbcd_pkg.sv
// Shared types, codes and widths of the NAND bus command decoder.
// No dependencies; the RTL files refer to this package by scoped names and the testbench imports it.
`timescale 1ns / 1ps

package nbcd_pkg;

  localparam int unsigned IO_W         = 8;
  localparam int unsigned PAGE_BYTES_W = 13;
  localparam int unsigned PPB_W        = 9;
  localparam int unsigned ADDR_W       = 27;
  localparam int unsigned COUNT_W      = 12;
  localparam int unsigned NUM_ADDR_BYTES = 5;
  localparam int unsigned SLOT_W       = 3;
  localparam int unsigned PROD1_W      = 18;
  localparam int unsigned PROD2_W      = 32;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [PAGE_BYTES_W-1:0] PAGE_BYTES_RST = 13'd2112;
  localparam logic [PPB_W-1:0]        PPB_RST        = 9'd64;
  localparam logic [COUNT_W-1:0]      COUNT_MAX      = 12'd4095;

  localparam logic [IO_W-1:0] OP_RESET           = 8'hFF;
  localparam logic [IO_W-1:0] OP_READ_ID         = 8'h90;
  localparam logic [IO_W-1:0] OP_ERASE           = 8'h60;
  localparam logic [IO_W-1:0] OP_PROGRAM         = 8'h80;
  localparam logic [IO_W-1:0] OP_ERASE_CONFIRM   = 8'hD0;
  localparam logic [IO_W-1:0] OP_PROGRAM_CONFIRM = 8'h10;
  localparam logic [IO_W-1:0] ID_DUMMY_ADDR      = 8'h00;

  typedef enum logic [0:0] {
    CFG_PAGE_BYTES      = 1'd0,
    CFG_PAGES_PER_BLOCK = 1'd1
  } cfg_idx_e;

  // Pin event recognized by the front end.
  typedef enum logic [1:0] {
    CYC_WE_RISE = 2'd0,
    CYC_WE_FALL = 2'd1,
    CYC_RE_RISE = 2'd2
  } cyc_kind_e;

  typedef struct packed {
    cyc_kind_e       kind;
    logic [IO_W-1:0] io;
    logic            cle;
    logic            ale;
  } cyc_t;

  typedef struct packed {
    logic [PAGE_BYTES_W-1:0] page_bytes;
    logic [PPB_W-1:0]        pages_per_block;
  } cfg_t;

  typedef enum logic [2:0] {
    MODE_IDLE          = 3'd0,
    MODE_ID_ADDR       = 3'd1,
    MODE_ID_DATA       = 3'd2,
    MODE_ERASE_ADDR    = 3'd3,
    MODE_ERASE_CONFIRM = 3'd4,
    MODE_PROG_ADDR     = 3'd5,
    MODE_PROG_DATA     = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    EV_COMMAND    = 3'd0,
    EV_ERASE_ADDR = 3'd1,
    EV_PROG_ADDR  = 3'd2,
    EV_DATA       = 3'd3,
    EV_PROG_DONE  = 3'd4,
    EV_ID         = 3'd5,
    EV_ERROR      = 3'd6,
    EV_UNKNOWN    = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    CALC_IDLE = 2'd0,
    CALC_MUL1 = 2'd1,
    CALC_MUL2 = 2'd2
  } calc_e;

endpackage

// File: rtl/nand_bus_command_decoder_core.sv
// Top level of the NAND bus command decoder: configuration registers and the
// front end / queue / back end chain. Depends on nbcd_pkg, nbcd_front,
// nbcd_fifo and nbcd_back.
`timescale 1ns / 1ps

// Decodes a stream of sampled NAND bus pins, one sample per transfer on the
// slave side. The front end takes a sample every clock while the four-entry
// event queue has room; it keeps the previous WE/RE levels and queues only
// samples that carry a WE rising edge, a WE falling edge or an RE rising edge
// with WE high. The back end runs the command state machine at one queued
// event per clock while no address multiply is running and the result
// register is free. The last address cycle of ERASE BLOCK or PROGRAM PAGE
// runs through the two registered multiply stages of the linear address
// ((block * pages_per_block + page) * page_bytes + column, saturating at
// 2^27-1). Each result is one master-side transfer: tuser carries the event
// code, tdata the value, address and byte count. Write page_bytes and
// pages_per_block only while no bus cycle is being decoded.

module nand_bus_command_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_wdata_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] io, [8] cle, [9] ale, [10] we, [11] re, [15:12] zero
  input  logic [15:0] s_axis_tdata,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] value, [34:8] flash_address, [46:35] byte_count, [47] zero
  output logic [47:0] m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]  m_axis_tuser
);

  logic [nbcd_pkg::PAGE_BYTES_W-1:0] page_bytes_q;
  logic [nbcd_pkg::PPB_W-1:0]        ppb_q;
  nbcd_pkg::cfg_t                    cfg;

  logic           push, fifo_full, fifo_empty, pop;
  nbcd_pkg::cyc_t push_data, head;

  nbcd_pkg::event_e                 ev;
  logic [nbcd_pkg::IO_W-1:0]        value;
  logic [nbcd_pkg::ADDR_W-1:0]      addr;
  logic [nbcd_pkg::COUNT_W-1:0]     count;

  // Configuration registers: writes to an index with no register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bytes_q <= nbcd_pkg::PAGE_BYTES_RST;
      ppb_q        <= nbcd_pkg::PPB_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nbcd_pkg::CFG_PAGE_BYTES:      page_bytes_q <= cfg_wdata_i;
        nbcd_pkg::CFG_PAGES_PER_BLOCK: ppb_q <= cfg_wdata_i[nbcd_pkg::PPB_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.page_bytes      = page_bytes_q;
  assign cfg.pages_per_block = ppb_q;

  // Edge detection and classification of the pin samples.
  nbcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .io_i        (s_axis_tdata[7:0]),
    .cle_i       (s_axis_tdata[8]),
    .ale_i       (s_axis_tdata[9]),
    .we_i        (s_axis_tdata[10]),
    .re_i        (s_axis_tdata[11]),
    .full_i      (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Hold queued bus events while the back end is busy or stalled.
  nbcd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (fifo_empty),
    .full_o      (fifo_full)
  );

  // Command decode, address arithmetic and the result register.
  nbcd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .head_i  (head),
    .empty_i (fifo_empty),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .event_o (ev),
    .value_o (value),
    .addr_o  (addr),
    .count_o (count)
  );

  assign m_axis_tuser = ev;
  assign m_axis_tdata = {1'b0, count, addr, value};

endmodule

// File: rtl/nbcd_front.sv
// Front end: WE/RE edge detection on the pin sample stream.
// Depends on nbcd_pkg; pushes classified bus events into nbcd_fifo.
`timescale 1ns / 1ps

module nbcd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [nbcd_pkg::IO_W-1:0] io_i,
  input  logic                     cle_i,
  input  logic                     ale_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic                     full_i,
  output logic                     push_o,
  output nbcd_pkg::cyc_t           push_data_o
);

  logic last_we_q, last_we_d;
  logic last_re_q, last_re_d;
  logic accept;
  logic we_rise, we_fall, re_rise;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;

  assign we_rise = we_i && !last_we_q;
  assign we_fall = !we_i && last_we_q;
  assign re_rise = re_i && !last_re_q;

  always_comb begin
    last_we_d = last_we_q;
    last_re_d = last_re_q;
    if (accept) begin
      last_we_d = we_i;
      last_re_d = re_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_we_q <= 1'b1;
      last_re_q <= 1'b1;
    end else begin
      last_we_q <= last_we_d;
      last_re_q <= last_re_d;
    end
  end

  // A WE rise wins over everything; a WE fall ends a read-ID phase; an RE rise
  // only matters while WE stays high. Samples with no such edge are dropped.
  always_comb begin
    push_data_o.io  = io_i;
    push_data_o.cle = cle_i;
    push_data_o.ale = ale_i;
    push_data_o.kind = nbcd_pkg::CYC_RE_RISE;
    push_o = 1'b0;
    if (we_rise) begin
      push_data_o.kind = nbcd_pkg::CYC_WE_RISE;
      push_o = accept;
    end else if (we_fall) begin
      push_data_o.kind = nbcd_pkg::CYC_WE_FALL;
      push_o = accept;
    end else if (re_rise && we_i) begin
      push_data_o.kind = nbcd_pkg::CYC_RE_RISE;
      push_o = accept;
    end
  end

endmodule

// File: rtl/nbcd_fifo.sv
// Short queue of decoded bus events between front end and back end.
// Depends on nbcd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module nbcd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  nbcd_pkg::cyc_t push_data_i,
  input  logic           pop_i,
  output nbcd_pkg::cyc_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  nbcd_pkg::cyc_t mem_q [nbcd_pkg::FIFO_DEPTH];
  logic [nbcd_pkg::FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [nbcd_pkg::FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [nbcd_pkg::FIFO_CW-1:0] count_q, count_d;
  logic do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == nbcd_pkg::FIFO_CW'(nbcd_pkg::FIFO_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + nbcd_pkg::FIFO_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + nbcd_pkg::FIFO_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + nbcd_pkg::FIFO_CW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - nbcd_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/nbcd_back.sv
// Back end: command decode state machine, address multiply pipeline and
// output register. Depends on nbcd_pkg; consumes entries from nbcd_fifo.
`timescale 1ns / 1ps

module nbcd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nbcd_pkg::cfg_t                cfg_i,
  input  nbcd_pkg::cyc_t                head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output nbcd_pkg::event_e              event_o,
  output logic [nbcd_pkg::IO_W-1:0]     value_o,
  output logic [nbcd_pkg::ADDR_W-1:0]   addr_o,
  output logic [nbcd_pkg::COUNT_W-1:0]  count_o
);

  nbcd_pkg::mode_e mode_q, mode_d, mode_v;
  nbcd_pkg::calc_e calc_q, calc_d;
  logic calc_col_q, calc_col_d;
  logic skip_q, skip_d;
  logic [nbcd_pkg::SLOT_W-1:0]  acc_q, acc_d, acc_inc, slot;
  logic [nbcd_pkg::COUNT_W-1:0] dcount_q, dcount_d, dcount_inc;
  logic [nbcd_pkg::IO_W-1:0]    abyte_q [nbcd_pkg::NUM_ADDR_BYTES];
  logic                         abyte_we;
  logic [nbcd_pkg::PROD1_W-1:0] prod1_q;
  logic [nbcd_pkg::PROD2_W-1:0] prod2;
  logic [nbcd_pkg::PPB_W-1:0]   blk;
  logic [5:0]                   page;
  logic [11:0]                  column;
  logic [nbcd_pkg::ADDR_W-1:0]  addr_sat;
  logic out_free, decode_en;

  logic                         res_fire;
  nbcd_pkg::event_e             res_ev;
  logic [nbcd_pkg::COUNT_W-1:0] res_cnt;

  assign out_free  = !valid_o || ready_i;
  assign pop_o     = !empty_i && (calc_q == nbcd_pkg::CALC_IDLE) && out_free;
  assign decode_en = pop_o && (head_i.kind == nbcd_pkg::CYC_WE_RISE) && !skip_q;

  // Any WE edge leaves the read-ID phase before the cycle itself is decoded.
  assign mode_v = (mode_q == nbcd_pkg::MODE_ID_DATA && head_i.kind != nbcd_pkg::CYC_RE_RISE)
                  ? nbcd_pkg::MODE_IDLE : mode_q;

  assign acc_inc    = acc_q + nbcd_pkg::SLOT_W'(1);
  assign slot       = (mode_v == nbcd_pkg::MODE_ERASE_ADDR)
                      ? acc_q + nbcd_pkg::SLOT_W'(2) : acc_q;
  assign dcount_inc = (dcount_q == nbcd_pkg::COUNT_MAX)
                      ? dcount_q : dcount_q + nbcd_pkg::COUNT_W'(1);

  // Next state
  always_comb begin
    mode_d     = mode_q;
    calc_d     = calc_q;
    calc_col_d = calc_col_q;
    skip_d     = skip_q;
    acc_d      = acc_q;
    dcount_d   = dcount_q;
    abyte_we   = 1'b0;
    if (pop_o) begin
      mode_d = mode_v;
      if (head_i.kind == nbcd_pkg::CYC_WE_RISE && skip_q) begin
        skip_d = 1'b0;
      end
    end
    if (decode_en) begin
      case (mode_v)
        nbcd_pkg::MODE_IDLE: begin
          if (head_i.cle) begin
            case (head_i.io)
              nbcd_pkg::OP_READ_ID: mode_d = nbcd_pkg::MODE_ID_ADDR;
              nbcd_pkg::OP_ERASE: begin
                mode_d = nbcd_pkg::MODE_ERASE_ADDR;
                acc_d  = '0;
              end
              nbcd_pkg::OP_PROGRAM: begin
                mode_d = nbcd_pkg::MODE_PROG_ADDR;
                acc_d  = '0;
              end
              default: mode_d = nbcd_pkg::MODE_IDLE;
            endcase
          end
        end
        nbcd_pkg::MODE_ID_ADDR: begin
          mode_d = (head_i.ale && head_i.io == nbcd_pkg::ID_DUMMY_ADDR)
                   ? nbcd_pkg::MODE_ID_DATA : nbcd_pkg::MODE_IDLE;
        end
        nbcd_pkg::MODE_ERASE_ADDR: begin
          if (!head_i.ale) begin
            mode_d = nbcd_pkg::MODE_IDLE;
          end else begin
            abyte_we = 1'b1;
            acc_d    = acc_inc;
            if (acc_inc >= nbcd_pkg::SLOT_W'(3)) begin
              mode_d     = nbcd_pkg::MODE_ERASE_CONFIRM;
              calc_d     = nbcd_pkg::CALC_MUL1;
              calc_col_d = 1'b0;
            end
          end
        end
        nbcd_pkg::MODE_ERASE_CONFIRM: begin
          mode_d = nbcd_pkg::MODE_IDLE;
          if (head_i.cle && head_i.io == nbcd_pkg::OP_ERASE_CONFIRM) begin
            skip_d = 1'b1;
          end
        end
        nbcd_pkg::MODE_PROG_ADDR: begin
          if (!head_i.ale) begin
            mode_d = nbcd_pkg::MODE_IDLE;
          end else begin
            abyte_we = 1'b1;
            acc_d    = acc_inc;
            if (acc_inc >= nbcd_pkg::SLOT_W'(nbcd_pkg::NUM_ADDR_BYTES)) begin
              mode_d     = nbcd_pkg::MODE_PROG_DATA;
              dcount_d   = '0;
              calc_d     = nbcd_pkg::CALC_MUL1;
              calc_col_d = 1'b1;
            end
          end
        end
        nbcd_pkg::MODE_PROG_DATA: begin
          if (!head_i.cle) begin
            dcount_d = dcount_inc;
          end else begin
            mode_d = nbcd_pkg::MODE_IDLE;
            if (head_i.io == nbcd_pkg::OP_PROGRAM_CONFIRM) begin
              skip_d = 1'b1;
            end
          end
        end
        default: mode_d = nbcd_pkg::MODE_IDLE;
      endcase
    end
    case (calc_q)
      nbcd_pkg::CALC_MUL1: calc_d = nbcd_pkg::CALC_MUL2;
      nbcd_pkg::CALC_MUL2: begin
        if (out_free) begin
          calc_d = nbcd_pkg::CALC_IDLE;
        end
      end
      default: ;
    endcase
  end

  // Decode result
  always_comb begin
    res_fire = 1'b0;
    res_ev   = nbcd_pkg::EV_ERROR;
    res_cnt  = '0;
    if (decode_en) begin
      case (mode_v)
        nbcd_pkg::MODE_IDLE: begin
          if (head_i.cle) begin
            res_fire = 1'b1;
            case (head_i.io)
              nbcd_pkg::OP_RESET, nbcd_pkg::OP_READ_ID,
              nbcd_pkg::OP_ERASE, nbcd_pkg::OP_PROGRAM: res_ev = nbcd_pkg::EV_COMMAND;
              default: res_ev = nbcd_pkg::EV_UNKNOWN;
            endcase
          end
        end
        nbcd_pkg::MODE_ID_ADDR: begin
          res_fire = !(head_i.ale && head_i.io == nbcd_pkg::ID_DUMMY_ADDR);
        end
        nbcd_pkg::MODE_ERASE_ADDR, nbcd_pkg::MODE_PROG_ADDR: begin
          res_fire = !head_i.ale;
        end
        nbcd_pkg::MODE_ERASE_CONFIRM: begin
          res_fire = 1'b1;
          if (head_i.cle && head_i.io == nbcd_pkg::OP_ERASE_CONFIRM) begin
            res_ev = nbcd_pkg::EV_COMMAND;
          end
        end
        nbcd_pkg::MODE_PROG_DATA: begin
          res_fire = 1'b1;
          if (!head_i.cle) begin
            res_ev  = nbcd_pkg::EV_DATA;
            res_cnt = dcount_inc;
          end else if (head_i.io == nbcd_pkg::OP_PROGRAM_CONFIRM) begin
            res_ev  = nbcd_pkg::EV_PROG_DONE;
            res_cnt = dcount_q;
          end
        end
        default: res_fire = 1'b0;
      endcase
    end else if (pop_o && head_i.kind == nbcd_pkg::CYC_RE_RISE
                 && mode_q == nbcd_pkg::MODE_ID_DATA) begin
      res_fire = 1'b1;
      res_ev   = nbcd_pkg::EV_ID;
    end
  end

  // Address: ((block * pages_per_block + page) * page_bytes + column),
  // one multiply per stage.
  assign blk    = {abyte_q[4][0], abyte_q[3]};
  assign page   = abyte_q[2][5:0];
  assign column = calc_col_q ? {abyte_q[1][3:0], abyte_q[0]} : 12'd0;
  assign prod2  = nbcd_pkg::PROD2_W'(prod1_q) * nbcd_pkg::PROD2_W'(cfg_i.page_bytes)
                + nbcd_pkg::PROD2_W'(column);
  assign addr_sat = (prod2[nbcd_pkg::PROD2_W-1:nbcd_pkg::ADDR_W] != '0)
                    ? '1 : prod2[nbcd_pkg::ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (abyte_we && slot < nbcd_pkg::SLOT_W'(nbcd_pkg::NUM_ADDR_BYTES)) begin
      abyte_q[slot] <= head_i.io;
    end
    if (calc_q == nbcd_pkg::CALC_MUL1) begin
      prod1_q <= nbcd_pkg::PROD1_W'(blk) * nbcd_pkg::PROD1_W'(cfg_i.pages_per_block)
               + nbcd_pkg::PROD1_W'(page);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= nbcd_pkg::MODE_IDLE;
      calc_q     <= nbcd_pkg::CALC_IDLE;
      calc_col_q <= 1'b0;
      skip_q     <= 1'b0;
      acc_q      <= '0;
      dcount_q   <= '0;
    end else begin
      mode_q     <= mode_d;
      calc_q     <= calc_d;
      calc_col_q <= calc_col_d;
      skip_q     <= skip_d;
      acc_q      <= acc_d;
      dcount_q   <= dcount_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (calc_q == nbcd_pkg::CALC_MUL2 && out_free) begin
      valid_o <= 1'b1;
    end else if (res_fire) begin
      valid_o <= 1'b1;
    end else if (ready_i) begin
      valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (calc_q == nbcd_pkg::CALC_MUL2 && out_free) begin
      event_o <= calc_col_q ? nbcd_pkg::EV_PROG_ADDR : nbcd_pkg::EV_ERASE_ADDR;
      value_o <= '0;
      addr_o  <= addr_sat;
      count_o <= '0;
    end else if (res_fire) begin
      event_o <= res_ev;
      value_o <= head_i.io;
      addr_o  <= '0;
      count_o <= res_cnt;
    end
  end

endmodule

// File: sim/nand_bus_command_decoder_core_tb.sv
// Self-checking testbench for nand_bus_command_decoder_core: pin samples in,
// decoded bus events out, each result compared with a built-in decoder model.
// Depends on nbcd_pkg and the core RTL only.
`timescale 1ns / 1ps

module nand_bus_command_decoder_core_tb;
  import nbcd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 16;   // settle time after the last due event
  localparam longint unsigned ADDR_SAT  = 64'd134217727;
  localparam int unsigned DIR_ROWS      = 27;

  // One pin sample; packs as io in the low byte, then cle, ale, we, re.
  typedef struct packed {
    logic       re;
    logic       we;
    logic       ale;
    logic       cle;
    logic [7:0] io;
  } pin_sample_t;

  // One decoded bus event as carried by a master-side transfer.
  typedef struct packed {
    event_e      ev;
    logic [7:0]  value;
    logic [26:0] addr;
    logic [11:0] count;
  } bus_event_t;

  typedef enum logic {
    ACT_WRITE = 1'b0,   // WE pulse latching io/cle/ale
    ACT_READ  = 1'b1    // RE pulse with WE held high
  } bus_act_e;

  typedef struct {
    bus_act_e   act;
    logic [7:0] io;
    logic       cle;
    logic       ale;
    bit         typed;   // want holds the result to see on the latching sample
    bus_event_t want;
  } script_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [12:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [7:0] io, [8] cle, [9] ale, [10] we, [11] re
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;    // [7:0] value, [34:8] flash_address, [46:35] byte_count
  logic [2:0]  m_axis_tuser;    // [2:0] event_res

  nand_bus_command_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model: pin edge tracking, command state and configuration mirror.
  // ---------------------------------------------------------------------------
  logic [12:0] page_bytes_cfg = PAGE_BYTES_RST;
  logic [8:0]  ppb_cfg        = PPB_RST;
  logic        last_we_pin    = 1'b1;
  logic        last_re_pin    = 1'b1;
  mode_e       cur_mode       = MODE_IDLE;
  logic [2:0]  addr_cycles    = '0;
  logic [7:0]  addr_bytes [5] = '{default: 8'h00};
  logic [11:0] data_bytes     = '0;
  logic        skip_cycle     = 1'b0;

  bus_event_t  due_events [$];   // decoded events still to come out, oldest first
  int unsigned mismatches     = 0;
  int unsigned latched_cycles = 0;
  int unsigned burst_left     = 0;
  bit          gaps_on        = 1'b1;

  function automatic bus_event_t make_ev(input event_e e, input logic [7:0] v,
                                         input logic [26:0] a, input logic [11:0] c);
    bus_event_t r;
    r.ev    = e;
    r.value = v;
    r.addr  = a;
    r.count = c;
    return r;
  endfunction

  // (block * pages_per_block + page) * page_bytes + column, clipped to 27 bits.
  function automatic logic [26:0] linear_addr(input bit with_col);
    longint unsigned blk, pg, col, a;
    blk = {addr_bytes[4][0], addr_bytes[3]};
    pg  = addr_bytes[2][5:0];
    col = with_col ? {addr_bytes[1][3:0], addr_bytes[0]} : 0;
    a   = (blk * ppb_cfg + pg) * page_bytes_cfg + col;
    return (a > ADDR_SAT) ? ADDR_SAT[26:0] : a[26:0];
  endfunction

  // Decode one latched bus cycle; returns 1 when it yields an event.
  function automatic bit decode_cycle(input logic [7:0] io, input logic cle,
                                      input logic ale, output bus_event_t ev);
    int idx;
    ev = '0;
    case (cur_mode)
      MODE_IDLE: begin
        if (!cle) return 1'b0;
        case (io)
          OP_RESET: ;
          OP_READ_ID: cur_mode = MODE_ID_ADDR;
          OP_ERASE: begin
            cur_mode      = MODE_ERASE_ADDR;
            addr_cycles   = '0;
            addr_bytes[0] = 8'h00;
            addr_bytes[1] = 8'h00;
          end
          OP_PROGRAM: begin
            cur_mode    = MODE_PROG_ADDR;
            addr_cycles = '0;
          end
          default: begin
            ev = make_ev(EV_UNKNOWN, io, '0, '0);
            return 1'b1;
          end
        endcase
        ev = make_ev(EV_COMMAND, io, '0, '0);
        return 1'b1;
      end
      MODE_ID_ADDR: begin
        if (ale && io == ID_DUMMY_ADDR) begin
          cur_mode = MODE_ID_DATA;
          return 1'b0;
        end
      end
      MODE_ERASE_ADDR: begin
        if (ale) begin
          // erase carries only the row bytes, so they land in slots 2..4
          idx             = (int'(addr_cycles) + 2) % 5;
          addr_bytes[idx] = io;
          addr_cycles++;
          if (addr_cycles < 3) return 1'b0;
          cur_mode = MODE_ERASE_CONFIRM;
          ev       = make_ev(EV_ERASE_ADDR, '0, linear_addr(1'b0), '0);
          return 1'b1;
        end
      end
      MODE_ERASE_CONFIRM: begin
        if (cle && io == OP_ERASE_CONFIRM) begin
          cur_mode   = MODE_IDLE;
          skip_cycle = 1'b1;
          ev         = make_ev(EV_COMMAND, io, '0, '0);
          return 1'b1;
        end
      end
      MODE_PROG_ADDR: begin
        if (ale) begin
          idx             = int'(addr_cycles) % 5;
          addr_bytes[idx] = io;
          addr_cycles++;
          if (addr_cycles < 5) return 1'b0;
          cur_mode   = MODE_PROG_DATA;
          data_bytes = '0;
          ev         = make_ev(EV_PROG_ADDR, '0, linear_addr(1'b1), '0);
          return 1'b1;
        end
      end
      MODE_PROG_DATA: begin
        if (!cle) begin
          if (data_bytes < COUNT_MAX) data_bytes++;
          ev = make_ev(EV_DATA, io, '0, data_bytes);
          return 1'b1;
        end
        if (io == OP_PROGRAM_CONFIRM) begin
          cur_mode   = MODE_IDLE;
          skip_cycle = 1'b1;
          ev         = make_ev(EV_PROG_DONE, io, '0, data_bytes);
          return 1'b1;
        end
      end
      default: begin
        cur_mode = MODE_IDLE;
        return 1'b0;
      end
    endcase
    // every path that falls through here is a protocol error
    cur_mode = MODE_IDLE;
    ev       = make_ev(EV_ERROR, io, '0, '0);
    return 1'b1;
  endfunction

  // Advance the model by one pin sample; returns 1 when an event is due.
  function automatic bit decode_pins(input pin_sample_t s, output bus_event_t ev);
    bit we_rise, re_rise, got;
    we_rise     = s.we && !last_we_pin;
    re_rise     = s.re && !last_re_pin;
    last_we_pin = s.we;
    last_re_pin = s.re;
    got         = 1'b0;
    ev          = '0;
    if (cur_mode == MODE_ID_DATA) begin
      if (!s.we || we_rise) begin
        cur_mode = MODE_IDLE;
      end else if (re_rise) begin
        ev  = make_ev(EV_ID, s.io, '0, '0);
        got = 1'b1;
      end
    end
    if (we_rise) begin
      if (skip_cycle) begin
        skip_cycle = 1'b0;
      end else begin
        got = decode_cycle(s.io, s.cle, s.ale, ev);
      end
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Slave side: drive one sample, hold it until the transfer, then predict.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input pin_sample_t s, input bit typed = 1'b0,
                             input bus_event_t want = '0);
    bus_event_t ev;
    bit         got;
    // drop valid for a random gap at the end of each burst
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, s};
    // ready seen at the falling edge means the transfer happens at the next rise
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    got = decode_pins(s, ev);
    if (typed) due_events.push_back(want);
    else if (got) due_events.push_back(ev);
    if (burst_left != 0) burst_left--;
  endtask

  // WE low with the cycle set up, then WE high to latch it.
  task automatic bus_write(input logic [7:0] io, input logic cle, input logic ale,
                           input bit typed = 1'b0, input bus_event_t want = '0);
    send_sample('{re: 1'b1, we: 1'b0, ale: ale, cle: cle, io: io});
    send_sample('{re: 1'b1, we: 1'b1, ale: ale, cle: cle, io: io}, typed, want);
    latched_cycles++;
  endtask

  // RE low then high with WE held high; io of the rising sample is the ID byte.
  task automatic bus_read(input logic [7:0] io, input bit typed = 1'b0,
                          input bus_event_t want = '0);
    send_sample('{re: 1'b0, we: 1'b1, ale: 1'b0, cle: 1'b0, io: 8'($urandom)});
    send_sample('{re: 1'b1, we: 1'b1, ale: 1'b0, cle: 1'b0, io: io}, typed, want);
    latched_cycles++;
  endtask

  // Bias address bytes toward the extremes so saturation shows up often.
  function automatic logic [7:0] addr_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'hff;
      2:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // PROGRAM PAGE: opcode, five address cycles, data, confirm. Unless intact,
  // an address cycle may lose ALE and the confirm may be wrong or missing.
  task automatic program_seq(input int unsigned data_len, input bit intact);
    int unsigned pick;
    bus_write(OP_PROGRAM, 1'b1, 1'b0);
    for (int i = 0; i < 5; i++) begin
      bus_write(addr_byte(), 1'b0, intact || ($urandom_range(0, 19) != 0));
    end
    for (int unsigned i = 0; i < data_len; i++) begin
      if ($urandom_range(0, 9) == 0) bus_read(8'($urandom));   // RE is ignored here
      bus_write(8'($urandom), 1'b0, 1'($urandom));
    end
    pick = $urandom_range(0, 19);
    if (intact || pick < 17) bus_write(OP_PROGRAM_CONFIRM, 1'b1, 1'b0);
    else if (pick < 19) bus_write(8'($urandom), 1'b1, 1'b0);
  endtask

  // Mostly well-formed command sequences with random content, some broken
  // ones and some raw pin noise, until quota more bus cycles have gone out.
  task automatic random_traffic(input int unsigned quota);
    int unsigned stop_at, pick, n;
    stop_at = latched_cycles + quota;
    while (latched_cycles < stop_at) begin
      // force the decoder back to idle so the next sequence starts clean
      if (cur_mode != MODE_IDLE) bus_write(8'h00, 1'b1, 1'b0);
      // burn the cycle that is ignored after a confirm
      if (skip_cycle) bus_write(8'($urandom), 1'($urandom), 1'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
        program_seq(n, 1'b0);
      end else if (pick < 60) begin
        bus_write(OP_ERASE, 1'b1, 1'b0);
        for (int i = 0; i < 3; i++) begin
          bus_write(addr_byte(), 1'b0, $urandom_range(0, 19) != 0);
        end
        if ($urandom_range(0, 9) != 0) bus_write(OP_ERASE_CONFIRM, 1'b1, 1'b0);
        else bus_write(8'($urandom), 1'($urandom), 1'($urandom));
      end else if (pick < 75) begin
        bus_write(OP_READ_ID, 1'b1, 1'b0);
        if ($urandom_range(0, 9) != 0) bus_write(ID_DUMMY_ADDR, 1'b0, 1'b1);
        else bus_write(8'($urandom), 1'($urandom), 1'($urandom));
        n = $urandom_range(0, 6);
        repeat (n) bus_read(8'($urandom));
      end else if (pick < 85) begin
        bus_write($urandom_range(0, 1) ? OP_RESET : 8'($urandom), 1'b1, 1'b0);
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) send_sample(pin_sample_t'(12'($urandom)));
      end
    end
  endtask

  // Write both registers back to back and mirror them in the model.
  task automatic set_config(input logic [12:0] pb, input logic [8:0] ppb);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PAGE_BYTES;
    cfg_wdata_i <= pb;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PAGES_PER_BLOCK;
    cfg_wdata_i <= {4'd0, ppb};
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    page_bytes_cfg = pb;
    ppb_cfg        = ppb;
  endtask

  // Stop sending, wait for every due event, then let trailing samples settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Master side: stall pattern and result checking.
  // ---------------------------------------------------------------------------
  int unsigned stall_mode  = 0;
  int unsigned stall_timer = 0;
  int unsigned stall_hold  = 0;
  int unsigned stall_phase = 0;

  // Switch between always ready, coin flips, one in four, and long stalls.
  always @(posedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_timer = $urandom_range(50, 300);
    end else begin
      stall_timer--;
    end
    stall_phase++;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom);
      2: m_axis_tready <= (stall_phase % 4 == 0);
      default: begin
        if (stall_hold == 0) begin
          m_axis_tready <= !m_axis_tready;
          stall_hold    = $urandom_range(0, 15);
        end else begin
          stall_hold--;
        end
      end
    endcase
  end

  task automatic report_mismatch(input string what, input bus_event_t got,
                                 input bus_event_t want);
    if (mismatches < 100) begin
      $display("%0t: %s: got ev %0d value %h addr %0d count %0d, want ev %0d value %h addr %0d count %0d",
               $realtime, what, got.ev, got.value, got.addr, got.count,
               want.ev, want.value, want.addr, want.count);
    end
    mismatches++;
  endtask

  // Outputs are stable at the falling edge; a transfer seen here completes at
  // the next rising edge.
  always @(negedge clk_i) begin
    bus_event_t seen;
    bus_event_t want;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      seen = make_ev(event_e'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[34:8],
                     m_axis_tdata[46:35]);
      if (due_events.size() == 0) begin
        report_mismatch("unexpected result", seen, '0);
      end else begin
        want = due_events.pop_front();
        if (seen !== want) report_mismatch("wrong result", seen, want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed script: reset, unknown opcode, READ ID with ID bytes, an erase
  // with address 0, a program at the address extremes with two data bytes,
  // the ignored cycle after each confirm, and two protocol errors.
  // ---------------------------------------------------------------------------
  script_row_t script_rows [DIR_ROWS] = '{
    '{ACT_WRITE, OP_RESET,   1'b1, 1'b0, 1'b1, '{EV_COMMAND, OP_RESET, 27'd0, 12'd0}},
    '{ACT_WRITE, 8'h00,      1'b0, 1'b0, 1'b0, '0},   // non-command cycle in idle
    '{ACT_WRITE, 8'h12,      1'b1, 1'b0, 1'b1, '{EV_UNKNOWN, 8'h12, 27'd0, 12'd0}},
    '{ACT_WRITE, OP_READ_ID, 1'b1, 1'b0, 1'b1, '{EV_COMMAND, OP_READ_ID, 27'd0, 12'd0}},
    '{ACT_WRITE, 8'h00,      1'b0, 1'b1, 1'b0, '0},   // dummy address, no result
    '{ACT_READ,  8'hec,      1'b0, 1'b0, 1'b1, '{EV_ID, 8'hec, 27'd0, 12'd0}},
    '{ACT_READ,  8'hff,      1'b0, 1'b0, 1'b1, '{EV_ID, 8'hff, 27'd0, 12'd0}},
    '{ACT_WRITE, OP_ERASE,   1'b1, 1'b0, 1'b1, '{EV_COMMAND, OP_ERASE, 27'd0, 12'd0}},
    '{ACT_WRITE, 8'h00,      1'b0, 1'b1, 1'b0, '0},
    '{ACT_WRITE, 8'h00,      1'b0, 1'b1, 1'b0, '0},
    '{ACT_WRITE, 8'h00,      1'b0, 1'b1, 1'b1, '{EV_ERASE_ADDR, 8'h00, 27'd0, 12'd0}},
    '{ACT_WRITE, OP_ERASE_CONFIRM, 1'b1, 1'b0, 1'b1,
      '{EV_COMMAND, OP_ERASE_CONFIRM, 27'd0, 12'd0}},
    '{ACT_WRITE, 8'h55,      1'b1, 1'b0, 1'b0, '0},   // ignored after the confirm
    '{ACT_WRITE, OP_PROGRAM, 1'b1, 1'b0, 1'b1, '{EV_COMMAND, OP_PROGRAM, 27'd0, 12'd0}},
    '{ACT_WRITE, 8'hff,      1'b0, 1'b1, 1'b0, '0},
    '{ACT_WRITE, 8'hff,      1'b0, 1'b1, 1'b0, '0},
    '{ACT_WRITE, 8'hff,      1'b0, 1'b1, 1'b0, '0},
    '{ACT_WRITE, 8'hff,      1'b0, 1'b1, 1'b0, '0},
    '{ACT_WRITE, 8'hff,      1'b0, 1'b1, 1'b0, '0},   // address from the model
    '{ACT_WRITE, 8'h00,      1'b0, 1'b0, 1'b1, '{EV_DATA, 8'h00, 27'd0, 12'd1}},
    '{ACT_WRITE, 8'hff,      1'b0, 1'b1, 1'b1, '{EV_DATA, 8'hff, 27'd0, 12'd2}},
    '{ACT_WRITE, OP_PROGRAM_CONFIRM, 1'b1, 1'b0, 1'b1,
      '{EV_PROG_DONE, OP_PROGRAM_CONFIRM, 27'd0, 12'd2}},
    '{ACT_WRITE, OP_READ_ID, 1'b1, 1'b0, 1'b0, '0},   // ignored after the confirm
    '{ACT_WRITE, OP_READ_ID, 1'b1, 1'b0, 1'b1, '{EV_COMMAND, OP_READ_ID, 27'd0, 12'd0}},
    '{ACT_WRITE, 8'h01,      1'b0, 1'b1, 1'b1, '{EV_ERROR, 8'h01, 27'd0, 12'd0}},
    '{ACT_WRITE, OP_ERASE,   1'b1, 1'b0, 1'b1, '{EV_COMMAND, OP_ERASE, 27'd0, 12'd0}},
    '{ACT_WRITE, 8'h33,      1'b0, 1'b0, 1'b1, '{EV_ERROR, 8'h33, 27'd0, 12'd0}}
  };

  // Register settings per phase: both extremes, zero, and all ones.
  logic [12:0] pb_plan  [1:5] = '{13'd4096, 13'd1, 13'd0,   13'd8191, 13'd512};
  logic [8:0]  ppb_plan [1:5] = '{9'd256,   9'd1,  9'd511,  9'd0,     9'd32};

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PAGE_BYTES;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the script with the reset values of the registers
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (script_rows[i].act == ACT_READ) begin
        bus_read(script_rows[i].io, script_rows[i].typed, script_rows[i].want);
      end else begin
        bus_write(script_rows[i].io, script_rows[i].cle, script_rows[i].ale,
                  script_rows[i].typed, script_rows[i].want);
      end
    end
    random_traffic(55);

    // each later phase: quiet the block, reprogram, run more traffic
    for (int p = 1; p <= 5; p++) begin
      drain_results();
      set_config(pb_plan[p], ppb_plan[p]);
      gaps_on = (p % 2 == 0);
      random_traffic(55);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
